/* sv/rgbser_pkg.sv */
// ----------------------------------------------------------------------------
// RGB LED serializer package
// Shared types, register indexes, hue wheel constants and the wheel function.
// ----------------------------------------------------------------------------
package rgbser_pkg;

  localparam int BITS_PER_PIXEL = 24;
  localparam int CNT_W = $clog2(BITS_PER_PIXEL);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BITS_PER_PIXEL - 1);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_RED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_GREEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_BLUE  = 3'd3;

  localparam logic MODE_FIXED   = 1'b0;
  localparam logic MODE_RAINBOW = 1'b1;

  localparam logic [7:0] HUE_SEG1 = 8'd85;
  localparam logic [7:0] HUE_SEG2 = 8'd170;
  localparam logic [7:0] HUE_MAX  = 8'd255;

  typedef struct packed {
    logic       pixel_lit;
    logic [2:0] row_index;
    logic [7:0] frame_hue;
  } pixel_t;

  typedef struct packed {
    logic data_bit;
    logic last_bit;
  } led_bit_t;

  // Green sits in the top byte so the packed value is the wire order.
  typedef struct packed {
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
  } color_t;

  typedef struct packed {
    logic       color_mode;
    logic [7:0] fixed_red;
    logic [7:0] fixed_green;
    logic [7:0] fixed_blue;
  } cfg_t;

  function automatic color_t hue_wheel(input logic [7:0] h);
    color_t c;
    c = '0;
    if (h <= HUE_SEG1) begin
      c.green = h;
      c.blue  = HUE_SEG1 - h;
    end else if (h <= HUE_SEG2) begin
      c.red   = h - HUE_SEG1;
      c.green = HUE_SEG2 - h;
    end else begin
      c.red   = HUE_MAX - h;
      c.blue  = h - HUE_SEG2;
    end
    return c;
  endfunction

endpackage

/* sv/rgbser_pixel_if.sv */
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel that carries one pixel item.
// ----------------------------------------------------------------------------
interface rgbser_pixel_if;
  logic                valid;
  logic                ready;
  rgbser_pkg::pixel_t  payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

/* sv/rgbser_bit_if.sv */
// ----------------------------------------------------------------------------
// LED bit channel
// Valid/ready channel that carries one serial LED data bit item.
// ----------------------------------------------------------------------------
interface rgbser_bit_if;
  logic                  valid;
  logic                  ready;
  rgbser_pkg::led_bit_t  payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

/* sv/rgb_led_pixel_serializer.sv */
// ----------------------------------------------------------------------------
// RGB LED pixel serializer
// Turns one picture pixel into the 24 GRB data bits of a one-wire LED,
// using either a fixed color or a hue wheel over frame hue plus row.
// ----------------------------------------------------------------------------
//   Channel  Dir  Item                                   Per item
//   pixel    in   pixel_lit, row_index, frame_hue        1
//   led      out  data_bit, last_bit                     24
//   cfg      in   cfg_we, cfg_index, cfg_data            write only
//
// Each pixel is sent as 24 output bits, one at a time, by the bit shifter.
// The first bit is offered once the pixel has passed the input register and the shifter.
// One further pixel waits in the input register while the shifter is busy.
// Reset clears all valid flags and the configuration; a stalled bit holds.
// ----------------------------------------------------------------------------
module rgb_led_pixel_serializer (
  input  logic                               clk,
  input  logic                               rst,
  rgbser_pixel_if.sink                       pixel,
  rgbser_bit_if.source                       led,
  input  logic                               cfg_we,
  input  logic [rgbser_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rgbser_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rgbser_pkg::*;

  cfg_t   cfg;
  logic   word_valid;
  logic   word_ready;
  color_t word;

  rgbser_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rgbser_pixel_stage u_pixel_stage (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (pixel.valid),
    .in_ready   (pixel.ready),
    .in_pixel   (pixel.payload),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word       (word)
  );

  rgbser_shifter u_shifter (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word       (word),
    .out_valid  (led.valid),
    .out_ready  (led.ready),
    .out_bit    (led.payload)
  );

endmodule

/* sv/rgbser_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the color mode and the fixed color, written through a plain port.
// ----------------------------------------------------------------------------
module rgbser_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rgbser_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rgbser_pkg::CFG_DATA_W-1:0]  cfg_data,
  output rgbser_pkg::cfg_t                   cfg
);
  import rgbser_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLOR_MODE:  cfg.color_mode  <= cfg_data[0];
        REG_FIXED_RED:   cfg.fixed_red   <= cfg_data;
        REG_FIXED_GREEN: cfg.fixed_green <= cfg_data;
        REG_FIXED_BLUE:  cfg.fixed_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* sv/rgbser_pixel_stage.sv */
// ----------------------------------------------------------------------------
// Pixel stage
// Input register for one pixel and the color lookup that feeds the shifter.
// ----------------------------------------------------------------------------
module rgbser_pixel_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  rgbser_pkg::cfg_t      cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rgbser_pkg::pixel_t    in_pixel,
  output logic                  word_valid,
  input  logic                  word_ready,
  output rgbser_pkg::color_t    word
);
  import rgbser_pkg::*;

  logic   hold_valid;
  pixel_t hold_pixel;
  logic   [7:0] hue;
  color_t wheel_color;

  assign in_ready   = !hold_valid || word_ready;
  assign word_valid = hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      hold_pixel <= in_pixel;
    end
  end

  assign hue         = hold_pixel.frame_hue + {5'd0, hold_pixel.row_index};
  assign wheel_color = hue_wheel(hue);

  always_comb begin
    if (!hold_pixel.pixel_lit) begin
      word = '0;
    end else if (cfg.color_mode == MODE_RAINBOW) begin
      word = wheel_color;
    end else begin
      word.green = cfg.fixed_green;
      word.red   = cfg.fixed_red;
      word.blue  = cfg.fixed_blue;
    end
  end

endmodule

/* sv/rgbser_shifter.sv */
// ----------------------------------------------------------------------------
// Bit shifter
// Shifts a 24-bit GRB word out MSB first and marks the last bit.
// ----------------------------------------------------------------------------
module rgbser_shifter (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  word_valid,
  output logic                  word_ready,
  input  rgbser_pkg::color_t    word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rgbser_pkg::led_bit_t  out_bit
);
  import rgbser_pkg::*;

  logic                      sh_valid;
  logic [BITS_PER_PIXEL-1:0] sh_word;
  logic [CNT_W-1:0]          bit_cnt;
  logic                      last;

  assign last       = (bit_cnt == LAST_BIT);
  assign word_ready = !sh_valid || (out_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      sh_valid <= 1'b0;
      bit_cnt  <= '0;
    end else if (word_ready) begin
      sh_valid <= word_valid;
      bit_cnt  <= '0;
      sh_word  <= word;
    end else if (out_ready) begin
      bit_cnt  <= bit_cnt + 1'b1;
      sh_word  <= {sh_word[BITS_PER_PIXEL-2:0], 1'b0};
    end
  end

  assign out_valid        = sh_valid;
  assign out_bit.data_bit = sh_word[BITS_PER_PIXEL-1];
  assign out_bit.last_bit = last;

endmodule
